@@ design/scft_pkg.sv @@
// Package for the second-chance frame table.
// Holds command, status, page-kind and write-back codes and the controller/datapath link structs.
// No dependencies.
package scft_pkg;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_ACCESS = 2'd2;
  localparam logic [1:0] CMD_RSVD   = 2'd3;

  localparam logic [1:0] ST_GRANT  = 2'd0;
  localparam logic [1:0] ST_EVICT  = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;
  localparam logic [1:0] ST_UNUSED = 2'd3;

  localparam logic [1:0] KIND_EXEC  = 2'd0;
  localparam logic [1:0] KIND_STACK = 2'd1;
  localparam logic [1:0] KIND_SWAP  = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  localparam logic [1:0] WB_NONE     = 2'd0;
  localparam logic [1:0] WB_NEW_SLOT = 2'd1;
  localparam logic [1:0] WB_OLD_SLOT = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       ld;
    logic       idx_zero;
    logic       idx_inc;
    logic       idx_pos;
    logic       rd_en;
    logic       pos_q;
    logic       frame_idx;
    logic       acc_clr;
    logic       shift_wr;
    logic       cnt_dec;
    logic       commit;
    logic       do_free;
    logic       do_access;
    logic       pay_rd;
    logic       res_set;
    logic [1:0] res_st;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       cnt_lt_lim;
    logic       idx_lt_cnt;
    logic       qv;
    logic       q_acc;
    logic       q_last;
    logic       q_match;
    logic       slot_free;
    logic       fi_ok;
    logic       out_busy;
    logic [1:0] cmd;
  } sts_t;

endpackage

@@ design/second_chance_frame_table.sv @@
// Top level of the second-chance frame table.
// Depends on scft_pkg, scft_ctrl and scft_dp.
//
//   channel  | direction | handshake           | payload
//   in_      | request   | in_tvalid/in_tready | in_tuser, in_tdata
//   out_     | result    | out_tvalid/ready    | out_tuser, out_tdata
//   cfg_     | write     | cfg_we              | cfg_wdata (usable_frames)
//
// One request at a time. Access and bad commands go from decode straight to the
// result step; allocation from the free pool checks one frame a cycle until one
// is free; eviction walks the age list one entry a cycle, then compacts it one
// entry a cycle; a free searches and compacts the age list. The result waits in
// an output register; a stalled result holds the controller in its result step.
// Reset is synchronous.
module second_chance_frame_table #(
  parameter int FRAMES     = 64,
  parameter int PAGE_BITS  = 20,
  parameter int SWAP_SLOTS = 1024
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // frame_index, page_number, owner_id, page_kind, swap_slot, is_write
  input  logic [(($clog2(FRAMES) + PAGE_BITS + 11 + $clog2(SWAP_SLOTS)) + 7) / 8 * 8 - 1:0]
               in_tdata,
  // cmd
  input  logic [1:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // granted_frame, victim_page, victim_owner, writeback, writeback_slot
  output logic [(($clog2(FRAMES) + PAGE_BITS + 10 + $clog2(SWAP_SLOTS)) + 7) / 8 * 8 - 1:0]
               out_tdata,
  // status
  output logic [1:0] out_tuser,
  input  logic cfg_we,
  input  logic [$clog2(FRAMES + 1)-1:0] cfg_wdata
);
  import scft_pkg::*;

  localparam int FB  = $clog2(FRAMES);
  localparam int SB  = $clog2(SWAP_SLOTS);
  localparam int CW  = $clog2(FRAMES + 1);
  localparam int IDW = ((FB + PAGE_BITS + 11 + SB) + 7) / 8 * 8;
  localparam int ODW = ((FB + PAGE_BITS + 10 + SB) + 7) / 8 * 8;

  ctl_t ctl;
  sts_t sts;

  scft_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  scft_dp #(
    .FRAMES     (FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .SWAP_SLOTS (SWAP_SLOTS),
    .FB         (FB),
    .SB         (SB),
    .CW         (CW),
    .IDW        (IDW),
    .ODW        (ODW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ design/scft_ctrl.sv @@
// Controller state machine of the second-chance frame table.
// Depends on scft_pkg; drives scft_dp through ctl_t and reads sts_t.
module scft_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           req_valid,
  output logic           req_ready,
  input  scft_pkg::sts_t sts,
  output scft_pkg::ctl_t ctl
);
  import scft_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DEC     = 4'd1;
  localparam logic [3:0] S_FSCAN   = 4'd2;
  localparam logic [3:0] S_ESCAN   = 4'd3;
  localparam logic [3:0] S_EFIRST  = 4'd4;
  localparam logic [3:0] S_EFIRST2 = 4'd5;
  localparam logic [3:0] S_EPAY    = 4'd6;
  localparam logic [3:0] S_FSRCH   = 4'd7;
  localparam logic [3:0] S_RES     = 4'd8;
  localparam logic [3:0] S_SHIFT   = 4'd9;
  localparam logic [3:0] S_COMMIT  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [1:0] st_r, st_nxt;

  assign req_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_DONE;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    st_nxt     = st_r;
    ctl        = '0;
    ctl.res_st = st_r;
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          ctl.ld    = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        ctl.idx_zero = 1'b1;
        case (sts.cmd)
          CMD_ALLOC: begin
            state_nxt = sts.cnt_lt_lim ? S_FSCAN : S_ESCAN;
          end
          CMD_FREE: begin
            if (sts.fi_ok) begin
              state_nxt = S_FSRCH;
            end else begin
              st_nxt    = ST_UNUSED;
              state_nxt = S_RES;
            end
          end
          CMD_ACCESS: begin
            ctl.do_access = sts.fi_ok;
            st_nxt        = sts.fi_ok ? ST_DONE : ST_UNUSED;
            state_nxt     = S_RES;
          end
          default: begin
            st_nxt    = ST_DONE;
            state_nxt = S_RES;
          end
        endcase
      end
      S_FSCAN: begin
        if (sts.slot_free) begin
          ctl.frame_idx = 1'b1;
          st_nxt        = ST_GRANT;
          state_nxt     = S_RES;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      S_ESCAN: begin
        ctl.rd_en   = sts.idx_lt_cnt;
        ctl.idx_inc = sts.idx_lt_cnt;
        if (sts.qv) begin
          if (!sts.q_acc) begin
            ctl.pos_q = 1'b1;
            state_nxt = S_EPAY;
          end else begin
            ctl.acc_clr = 1'b1;
            // Every frame had its second chance: fall back to the oldest one.
            if (sts.q_last) begin
              ctl.idx_zero = 1'b1;
              state_nxt    = S_EFIRST;
            end
          end
        end
      end
      S_EFIRST: begin
        ctl.rd_en   = 1'b1;
        ctl.idx_inc = 1'b1;
        state_nxt   = S_EFIRST2;
      end
      S_EFIRST2: begin
        ctl.pos_q = 1'b1;
        state_nxt = S_EPAY;
      end
      S_EPAY: begin
        ctl.pay_rd = 1'b1;
        st_nxt     = ST_EVICT;
        state_nxt  = S_RES;
      end
      S_FSRCH: begin
        ctl.rd_en   = sts.idx_lt_cnt;
        ctl.idx_inc = sts.idx_lt_cnt;
        if (sts.qv && sts.q_match) begin
          ctl.pos_q = 1'b1;
          st_nxt    = ST_DONE;
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (!sts.out_busy) begin
          ctl.res_set = 1'b1;
          ctl.idx_pos = 1'b1;
          if (st_r == ST_GRANT) begin
            state_nxt = S_COMMIT;
          end else if (st_r == ST_EVICT ||
                       (sts.cmd == CMD_FREE && st_r == ST_DONE)) begin
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SHIFT: begin
        ctl.rd_en    = sts.idx_lt_cnt;
        ctl.idx_inc  = sts.idx_lt_cnt;
        ctl.shift_wr = sts.qv;
        if (!sts.idx_lt_cnt && !sts.qv) begin
          ctl.cnt_dec = 1'b1;
          if (sts.cmd == CMD_ALLOC) begin
            state_nxt = S_COMMIT;
          end else begin
            ctl.do_free = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_COMMIT: begin
        ctl.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/scft_dp.sv @@
// Datapath of the second-chance frame table: frame flags, age list memory,
// page record memory, counters and the result register. Depends on scft_pkg.
module scft_dp #(
  parameter int FRAMES     = 64,
  parameter int PAGE_BITS  = 20,
  parameter int SWAP_SLOTS = 1024,
  parameter int FB         = 6,
  parameter int SB         = 10,
  parameter int CW         = 7,
  parameter int IDW        = 48,
  parameter int ODW        = 48
) (
  input  logic           clk,
  input  logic           rst_n,
  input  scft_pkg::ctl_t ctl,
  output scft_pkg::sts_t sts,
  input  logic [IDW-1:0] in_tdata,
  input  logic [1:0]     in_tuser,
  input  logic           cfg_we,
  input  logic [CW-1:0]  cfg_wdata,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [ODW-1:0] out_tdata,
  output logic [1:0]     out_tuser
);
  import scft_pkg::*;

  localparam int PW = 2 + SB + PAGE_BITS + 8;
  localparam logic [SB:0] SLOT_LIM = (SB+1)'(SWAP_SLOTS);
  localparam logic [CW-1:0] FR_CNT = CW'(FRAMES);

  // Request fields.
  logic [1:0]           cmd_r;
  logic [FB-1:0]        fi_r;
  logic [PAGE_BITS-1:0] page_r;
  logic [7:0]           owner_r;
  logic [1:0]           kind_r;
  logic [SB-1:0]        slot_r;
  logic                 wr_r;
  logic [SB-1:0]        slot_in;
  logic [SB:0]          slot_ext;

  logic [CW-1:0]     usable_r;
  logic [CW-1:0]     lim;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     idx_r;
  logic [FB-1:0]     pos_r;
  logic [FB-1:0]     frame_r;
  logic [FRAMES-1:0] in_use_r;
  logic [FRAMES-1:0] acc_r;
  logic [FRAMES-1:0] dirty_r;

  logic [FB-1:0] amem [FRAMES];
  logic [PW-1:0] pmem [FRAMES];
  logic [FB-1:0] q_r;
  logic [FB-1:0] qidx_r;
  logic          qv_r;
  logic [PW-1:0] pq_r;

  logic           out_valid_r;
  logic [1:0]     o_st_r;
  logic [FB-1:0]  o_frame_r;
  logic [PAGE_BITS-1:0] o_page_r;
  logic [7:0]     o_owner_r;
  logic [1:0]     o_wb_r;
  logic [SB-1:0]  o_slot_r;

  logic [1:0]           v_kind;
  logic [SB-1:0]        v_slot;
  logic [PAGE_BITS-1:0] v_page;
  logic [7:0]           v_owner;
  logic                 v_dirty;
  logic [1:0]           wb;
  logic [SB-1:0]        wb_slot;

  // A slot code at or beyond the slot count folds back once.
  assign slot_ext = {1'b0, in_tdata[FB+PAGE_BITS+10 +: SB]};
  assign slot_in  = (slot_ext >= SLOT_LIM) ? SB'(slot_ext - SLOT_LIM) : slot_ext[SB-1:0];

  always_comb begin
    if (usable_r == '0) begin
      lim = CW'(1);
    end else if (usable_r > FR_CNT) begin
      lim = FR_CNT;
    end else begin
      lim = usable_r;
    end
  end

  always_comb begin
    sts            = '0;
    sts.cnt_lt_lim = cnt_r < lim;
    sts.idx_lt_cnt = idx_r < cnt_r;
    sts.qv         = qv_r;
    sts.q_acc      = acc_r[q_r];
    sts.q_last     = CW'(qidx_r) == (cnt_r - CW'(1));
    sts.q_match    = q_r == fi_r;
    sts.slot_free  = !in_use_r[idx_r[FB-1:0]];
    sts.fi_ok      = (CW'(fi_r) < FR_CNT) && in_use_r[fi_r];
    sts.out_busy   = out_valid_r && !out_tready;
    sts.cmd        = cmd_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      cmd_r   <= in_tuser;
      fi_r    <= in_tdata[FB-1:0];
      page_r  <= in_tdata[FB +: PAGE_BITS];
      owner_r <= in_tdata[FB+PAGE_BITS +: 8];
      kind_r  <= in_tdata[FB+PAGE_BITS+8 +: 2];
      slot_r  <= slot_in;
      wr_r    <= in_tdata[FB+PAGE_BITS+10+SB];
    end
    if (ctl.pos_q) begin
      pos_r   <= qidx_r;
      frame_r <= q_r;
    end else if (ctl.frame_idx) begin
      frame_r <= idx_r[FB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usable_r <= FR_CNT;
      cnt_r    <= '0;
      idx_r    <= '0;
      qv_r     <= 1'b0;
      in_use_r <= '0;
      acc_r    <= '0;
      dirty_r  <= '0;
    end else begin
      if (cfg_we) begin
        usable_r <= cfg_wdata;
      end
      if (ctl.idx_zero) begin
        idx_r <= '0;
      end else if (ctl.idx_pos) begin
        idx_r <= CW'(pos_r) + CW'(1);
      end else if (ctl.idx_inc) begin
        idx_r <= idx_r + CW'(1);
      end
      qv_r <= ctl.rd_en;
      if (ctl.cnt_dec) begin
        cnt_r <= cnt_r - CW'(1);
      end else if (ctl.commit) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (ctl.acc_clr) begin
        acc_r[q_r] <= 1'b0;
      end
      if (ctl.do_access) begin
        acc_r[fi_r] <= 1'b1;
        if (wr_r) begin
          dirty_r[fi_r] <= 1'b1;
        end
      end
      if (ctl.do_free) begin
        in_use_r[fi_r] <= 1'b0;
        acc_r[fi_r]    <= 1'b0;
        dirty_r[fi_r]  <= 1'b0;
      end
      if (ctl.commit) begin
        in_use_r[frame_r] <= 1'b1;
        acc_r[frame_r]    <= 1'b0;
        dirty_r[frame_r]  <= 1'b0;
      end
    end
  end

  // Age list: entry 0 is the oldest frame.
  always_ff @(posedge clk) begin
    if (ctl.shift_wr) begin
      amem[qidx_r - FB'(1)] <= q_r;
    end else if (ctl.commit) begin
      amem[cnt_r[FB-1:0]] <= frame_r;
    end
    if (ctl.rd_en) begin
      q_r    <= amem[idx_r[FB-1:0]];
      qidx_r <= idx_r[FB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      pmem[frame_r] <= {kind_r, slot_r, page_r, owner_r};
    end
    if (ctl.pay_rd) begin
      pq_r <= pmem[frame_r];
    end
  end

  assign {v_kind, v_slot, v_page, v_owner} = pq_r;
  assign v_dirty = dirty_r[frame_r];

  always_comb begin
    wb      = WB_NONE;
    wb_slot = '0;
    case (v_kind)
      KIND_EXEC:  wb = v_dirty ? WB_NEW_SLOT : WB_NONE;
      KIND_STACK: wb = WB_NEW_SLOT;
      KIND_SWAP: begin
        if (v_dirty) begin
          wb      = WB_OLD_SLOT;
          wb_slot = v_slot;
        end
      end
      default: wb = WB_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.res_set) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_set) begin
      o_st_r    <= ctl.res_st;
      o_frame_r <= (ctl.res_st == ST_GRANT || ctl.res_st == ST_EVICT) ? frame_r : '0;
      if (ctl.res_st == ST_EVICT) begin
        o_page_r  <= v_page;
        o_owner_r <= v_owner;
        o_wb_r    <= wb;
        o_slot_r  <= wb_slot;
      end else begin
        o_page_r  <= '0;
        o_owner_r <= '0;
        o_wb_r    <= WB_NONE;
        o_slot_r  <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_st_r;
  assign out_tdata  = ODW'({o_slot_r, o_wb_r, o_owner_r, o_page_r, o_frame_r});

endmodule
